// ===== design/first_fit_interval_row_packer_defines.svh =====
// assertion macros shared by the row packer rtl
// needs clk and rst_n in the scope where a macro is used
`ifndef FIRST_FIT_INTERVAL_ROW_PACKER_DEFINES_SVH
`define FIRST_FIT_INTERVAL_ROW_PACKER_DEFINES_SVH

// same-cycle implication
`define FFIRP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFIRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ffirp_pkg.sv =====
// shared types and fixed field widths of the interval row packer
// no dependencies
package ffirp_pkg;

    localparam int CHROM_FIELD_W = 5;
    localparam int POS_W         = 31;
    localparam int ROW_FIELD_W   = 6;
    localparam int COUNT_FIELD_W = 7;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_COUNT  = 5'b00010,
        S_LOAD   = 5'b00100,
        S_SCAN   = 5'b01000,
        S_FINISH = 5'b10000
    } seq_state_t;

    typedef struct packed {
        logic clear_all;
        logic wr_en;
    } count_ctl_t;

endpackage

// ===== design/ffirp_count_store.sv =====
// per-chromosome row count store with one valid bit per entry
// uses ffirp_pkg::count_ctl_t; an entry that is not valid reads as zero
module ffirp_count_store #(
    parameter int DEPTH  = 32,
    parameter int DATA_W = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ffirp_pkg::count_ctl_t               ctl,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [DATA_W-1:0]                   wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                   rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (ctl.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== design/first_fit_interval_row_packer.sv =====
// Places one interval per transaction into the first row of its chromosome whose
// last stored end is at or before the interval start, opening a new row when none
// fits and the chromosome has a free row, else flagging overflow. The row-end memory
// has one read port and the sequencer walks the chromosome's rows one per cycle.
// in_ready is high only while idle, so the next transaction is accepted at the
// earliest in the cycle in which the result is presented; a finished result waits
// in the output register, and the next one stalls until it is taken. No clearing
// pass after reset.
// depends on ffirp_pkg, ffirp_count_store and first_fit_interval_row_packer_defines.svh
`include "first_fit_interval_row_packer_defines.svh"

module first_fit_interval_row_packer #(
    parameter int MAX_ROWS   = 64,
    parameter int NUM_CHROMS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 first_of_set,
    input  logic [ffirp_pkg::CHROM_FIELD_W-1:0]  chromosome,
    input  logic [ffirp_pkg::POS_W-1:0]          interval_start,
    input  logic [ffirp_pkg::POS_W-1:0]          interval_end,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ffirp_pkg::ROW_FIELD_W-1:0]    assigned_row,
    output logic                                 opened_row,
    output logic [ffirp_pkg::COUNT_FIELD_W-1:0]  rows_in_use,
    output logic                                 overflow
);

    localparam int CHROM_W  = NUM_CHROMS > 1 ? $clog2(NUM_CHROMS) : 1;
    localparam int ROW_W    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W    = $clog2(MAX_ROWS + 1);
    localparam int ENTRIES  = NUM_CHROMS * MAX_ROWS;
    localparam int ADDR_W   = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
    localparam int CODES    = 2 ** ffirp_pkg::CHROM_FIELD_W;
    localparam int POS_W    = ffirp_pkg::POS_W;
    localparam int ROW_FW   = ffirp_pkg::ROW_FIELD_W;
    localparam int COUNT_FW = ffirp_pkg::COUNT_FIELD_W;

    // chromosome code to row-set index, wrapping at NUM_CHROMS
    function automatic logic [CODES*CHROM_W-1:0] build_chrom_map();
        logic [CODES*CHROM_W-1:0] tab;
        int                       r;
        tab = '0;
        r   = 0;
        for (int i = 0; i < CODES; i++)
        begin
            tab[i*CHROM_W +: CHROM_W] = CHROM_W'(r);
            r = (r + 1 == NUM_CHROMS) ? 0 : r + 1;
        end
        return tab;
    endfunction

    localparam logic [CODES*CHROM_W-1:0] CHROM_MAP = build_chrom_map();

    ffirp_pkg::seq_state_t state_reg, state_next;

    logic [CHROM_W-1:0]  chrom_reg;
    logic [POS_W-1:0]    start_reg;
    logic [POS_W-1:0]    end_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [CNT_W-1:0]    rd_row_reg,  rd_row_next;
    logic [ROW_W-1:0]    cmp_row_reg, cmp_row_next;
    logic                pend_reg,    pend_next;
    logic                hit_reg,     hit_next;
    logic [ROW_W-1:0]    hit_row_reg, hit_row_next;
    logic [POS_W-1:0]    ram_q_reg;
    logic                out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]    res_row_reg;
    logic [CNT_W-1:0]    res_count_reg;
    logic                res_open_reg;
    logic                res_ovf_reg;

    logic [POS_W-1:0]    end_mem [ENTRIES];

    logic                in_fire;
    logic                issue_ok;
    logic                finish_go;
    logic                room;
    logic                do_open;
    logic                ram_we;
    logic [ROW_W-1:0]    wr_row;
    logic [ADDR_W-1:0]   ram_ra;
    logic [ADDR_W-1:0]   ram_wa;
    logic [CNT_W-1:0]    store_count;
    logic [CNT_W-1:0]    count_plus;

    ffirp_pkg::count_ctl_t count_ctl;

    assign in_ready  = (state_reg == ffirp_pkg::S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign issue_ok  = (rd_row_reg < count_reg);
    assign finish_go = (state_reg == ffirp_pkg::S_FINISH) && (!out_valid_reg || out_ready);
    assign room      = (count_reg != CNT_W'(MAX_ROWS));
    assign do_open   = !hit_reg && room;
    assign count_plus = count_reg + CNT_W'(1);
    assign wr_row    = hit_reg ? hit_row_reg : count_reg[ROW_W-1:0];
    assign ram_we    = finish_go && (hit_reg || room);
    assign ram_ra    = base_reg + ADDR_W'(rd_row_reg[ROW_W-1:0]);
    assign ram_wa    = base_reg + ADDR_W'(wr_row);

    assign count_ctl.clear_all = in_fire && first_of_set;
    assign count_ctl.wr_en     = finish_go && do_open;

    ffirp_count_store #(
        .DEPTH  (NUM_CHROMS),
        .DATA_W (CNT_W)
    ) u_count_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (count_ctl),
        .wr_addr (chrom_reg),
        .wr_data (count_plus),
        .rd_addr (chrom_reg),
        .rd_data (store_count)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_row_next    = rd_row_reg;
        cmp_row_next   = cmp_row_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        hit_row_next   = hit_row_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ffirp_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ffirp_pkg::S_COUNT;
                end
            end
            ffirp_pkg::S_COUNT:
            begin
                state_next = ffirp_pkg::S_LOAD;
            end
            ffirp_pkg::S_LOAD:
            begin
                count_next  = store_count;
                rd_row_next = '0;
                pend_next   = 1'b0;
                hit_next    = 1'b0;
                state_next  = ffirp_pkg::S_SCAN;
            end
            ffirp_pkg::S_SCAN:
            begin
                pend_next = issue_ok;
                if (issue_ok)
                begin
                    rd_row_next  = rd_row_reg + CNT_W'(1);
                    cmp_row_next = rd_row_reg[ROW_W-1:0];
                end
                if (pend_reg && (start_reg >= ram_q_reg))
                begin
                    hit_next     = 1'b1;
                    hit_row_next = cmp_row_reg;
                    state_next   = ffirp_pkg::S_FINISH;
                end
                else if (!pend_reg && !issue_ok)
                begin
                    hit_next   = 1'b0;
                    state_next = ffirp_pkg::S_FINISH;
                end
            end
            ffirp_pkg::S_FINISH:
            begin
                if (finish_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ffirp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffirp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffirp_pkg::S_IDLE;
            count_reg     <= '0;
            rd_row_reg    <= '0;
            cmp_row_reg   <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            hit_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_row_reg    <= rd_row_next;
            cmp_row_reg   <= cmp_row_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            hit_row_reg   <= hit_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // transaction capture and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            chrom_reg <= CHROM_MAP[chromosome*CHROM_W +: CHROM_W];
            start_reg <= interval_start;
            end_reg   <= interval_end;
        end
        if (state_reg == ffirp_pkg::S_COUNT)
        begin
            base_reg <= ADDR_W'(chrom_reg) * ADDR_W'(MAX_ROWS);
        end
        if (finish_go)
        begin
            res_row_reg   <= (hit_reg || room) ? wr_row : '0;
            res_count_reg <= do_open ? count_plus : count_reg;
            res_open_reg  <= do_open;
            res_ovf_reg   <= !hit_reg && !room;
        end
    end

    // row end memory
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            end_mem[ram_wa] <= end_reg;
        end
        ram_q_reg <= end_mem[ram_ra];
    end

    assign out_valid    = out_valid_reg;
    assign assigned_row = ROW_FW'(res_row_reg);
    assign opened_row   = res_open_reg;
    assign rows_in_use  = COUNT_FW'(res_count_reg);
    assign overflow     = res_ovf_reg;

    `FFIRP_ASSERT_NEXT(a_accept_starts, in_fire, state_reg == ffirp_pkg::S_COUNT, "accept did not start lookup")
    `FFIRP_ASSERT_IMPL(a_scan_bound, state_reg == ffirp_pkg::S_SCAN, rd_row_reg <= count_reg, "scan ran past row count")
    `FFIRP_ASSERT_IMPL(a_ovf_result, out_valid_reg && res_ovf_reg, !res_open_reg && res_row_reg == '0, "overflow result not clean")
    `FFIRP_ASSERT_IMPL(a_open_count, out_valid_reg && res_open_reg, res_count_reg == CNT_W'(res_row_reg) + CNT_W'(1), "opened row not last row")

endmodule
